// File: sv/gbse_pkg.sv
// gbse_pkg: shared types, codes and coefficient tables for the Gaussian blur
// and Sobel edge block. No dependencies; every other file imports it.
package gbse_pkg;

    // input item: op code and grey pixel
    typedef struct packed {
        logic       op;
        logic [7:0] pixel;
    } gbse_in_t;

    // result item
    typedef struct packed {
        logic [7:0] blurred;
        logic [7:0] edge_res;
        logic       frame_last;
    } gbse_out_t;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // register indexes (paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // x/159 == (x*52759) >> 23 for x < 2**16
    localparam logic [15:0] DIV_MUL   = 16'd52759;
    localparam int          DIV_SHIFT = 23;

    localparam logic [3:0] GAUSS_K [5][5] = '{
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
    };

    localparam logic signed [2:0] SOBEL_X [3][3] = '{
        '{-3'sd1, 3'sd0, 3'sd1},
        '{-3'sd2, 3'sd0, 3'sd2},
        '{-3'sd1, 3'sd0, 3'sd1}
    };

    localparam logic signed [2:0] SOBEL_Y [3][3] = '{
        '{-3'sd1, -3'sd2, -3'sd1},
        '{ 3'sd0,  3'sd0,  3'sd0},
        '{ 3'sd1,  3'sd2,  3'sd1}
    };

    // controller -> datapath commands
    typedef struct packed {
        logic accept;
        logic in_write;
        logic bl_start;
        logic bl_rd;
        logic bl_acc;
        logic bl_div;
        logic bl_wr;
        logic tick_inc;
        logic bv_rd;
        logic bv_cap;
        logic sb_start;
        logic sb_rd;
        logic sb_acc;
        logic sq;
        logic sum;
        logic rt_step;
        logic out_load;
    } gbse_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic item_flush;
        logic in_active;
        logic blur_go;
        logic out_go;
        logic bl_last;
        logic sb_last;
        logic rt_last;
        logic border;
        logic out_full;
    } gbse_status_t;

endpackage

// File: sv/gbse_ctrl.sv
// gbse_ctrl: sequencer that walks one item through input write, blur,
// Sobel and square root. Depends on gbse_pkg.
module gbse_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  gbse_pkg::gbse_status_t status,
    output gbse_pkg::gbse_cmd_t    cmd
);
    import gbse_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_BL_RD  = 4'd2;
    localparam logic [3:0] S_BL_ACC = 4'd3;
    localparam logic [3:0] S_BL_DIV = 4'd4;
    localparam logic [3:0] S_BL_WR  = 4'd5;
    localparam logic [3:0] S_OUTCHK = 4'd6;
    localparam logic [3:0] S_BV     = 4'd7;
    localparam logic [3:0] S_SB_RD  = 4'd8;
    localparam logic [3:0] S_SB_ACC = 4'd9;
    localparam logic [3:0] S_SQ     = 4'd10;
    localparam logic [3:0] S_SUM    = 4'd11;
    localparam logic [3:0] S_RT     = 4'd12;
    localparam logic [3:0] S_LOAD   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.in_active && status.item_flush)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.in_write = status.in_active;
                    if (status.blur_go)
                    begin
                        cmd.bl_start = 1'b1;
                        state_next   = S_BL_RD;
                    end
                    else
                    begin
                        state_next = S_OUTCHK;
                    end
                end
            end
            S_BL_RD:
            begin
                cmd.bl_rd  = 1'b1;
                state_next = S_BL_ACC;
            end
            S_BL_ACC:
            begin
                cmd.bl_acc = 1'b1;
                state_next = status.bl_last ? S_BL_DIV : S_BL_RD;
            end
            S_BL_DIV:
            begin
                cmd.bl_div = 1'b1;
                state_next = S_BL_WR;
            end
            S_BL_WR:
            begin
                cmd.bl_wr  = 1'b1;
                state_next = S_OUTCHK;
            end
            S_OUTCHK:
            begin
                if (status.out_go)
                begin
                    cmd.bv_rd  = 1'b1;
                    state_next = S_BV;
                end
                else
                begin
                    cmd.tick_inc = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_BV:
            begin
                cmd.bv_cap = 1'b1;
                if (status.border)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.sb_start = 1'b1;
                    state_next   = S_SB_RD;
                end
            end
            S_SB_RD:
            begin
                cmd.sb_rd  = 1'b1;
                state_next = S_SB_ACC;
            end
            S_SB_ACC:
            begin
                cmd.sb_acc = 1'b1;
                state_next = status.sb_last ? S_SQ : S_SB_RD;
            end
            S_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_RT;
            end
            S_RT:
            begin
                cmd.rt_step = 1'b1;
                if (status.rt_last)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/gbse_dp.sv
// gbse_dp: line memories, position counters, blur MAC, Sobel MAC, square
// root and the output register. Depends on gbse_pkg.
module gbse_dp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gbse_pkg::gbse_in_t     in_data,
    input  logic                   cfg_write,
    input  logic [WW-1:0]          w_eff,
    input  logic [RW-1:0]          h_eff,
    input  gbse_pkg::gbse_cmd_t    cmd,
    output gbse_pkg::gbse_status_t status,
    output logic                   out_valid,
    input  logic                   out_stall,
    output gbse_pkg::gbse_out_t    out_data
);
    import gbse_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int TW    = $clog2(3 * MAX_WIDTH + 4);
    localparam int IN_AW = CW + 3;
    localparam int BL_AW = CW + 2;

    // line memories: 8 input rows, 4 blurred rows
    logic [7:0] in_mem [2**IN_AW];
    logic [7:0] bl_mem [2**BL_AW];

    // item
    logic       op_reg;
    logic [7:0] pixel_reg;

    // positions
    logic [RW-1:0] in_row_reg, blur_row_reg, out_row_reg;
    logic [CW-1:0] in_col_reg, blur_col_reg, out_col_reg;
    logic [TW-1:0] tick_reg;

    // blur
    logic [2:0]  bl_dr_reg, bl_dc_reg;
    logic        tap_ok_reg;
    logic [3:0]  coef_reg;
    logic [7:0]  in_rdata_reg;
    logic [15:0] acc_reg;
    logic [31:0] prod_reg;

    // sobel / root
    logic [1:0]         sb_i_reg, sb_j_reg;
    logic [7:0]         bl_rdata_reg;
    logic [7:0]         bv_reg;
    logic signed [11:0] gx_reg, gy_reg;
    logic signed [23:0] sqx_reg;
    logic [21:0]        sum_reg;
    logic [7:0]         root_reg;
    logic [2:0]         rt_bit_reg;

    logic      out_valid_reg;
    gbse_out_t out_data_reg;

    // thresholds
    logic [TW-1:0] thr2, thr3;
    assign thr2 = TW'({w_eff, 1'b0}) + TW'(2);
    assign thr3 = TW'(w_eff) + TW'({w_eff, 1'b0}) + TW'(3);

    // wrap flags
    logic in_wrap, blur_wrap, out_wrap;
    assign in_wrap   = (WW'(in_col_reg) + WW'(1)) >= w_eff;
    assign blur_wrap = (WW'(blur_col_reg) + WW'(1)) >= w_eff;
    assign out_wrap  = (WW'(out_col_reg) + WW'(1)) >= w_eff;

    logic border, last;
    assign border = (w_eff < WW'(3)) || (h_eff < RW'(3)) || (out_row_reg == '0)
                 || (out_col_reg == '0) || (out_row_reg >= h_eff - RW'(1))
                 || (WW'(out_col_reg) >= w_eff - WW'(1));
    assign last   = (out_row_reg == h_eff - RW'(1)) && (WW'(out_col_reg) == w_eff - WW'(1));

    // blur tap address, padded taps masked
    logic [RW:0]       rr_u, rr_m2;
    logic [CW:0]       cc_u, cc_m2;
    logic              tap_ok;
    logic [IN_AW-1:0]  bl_raddr;
    assign rr_u   = {1'b0, blur_row_reg} + (RW+1)'(bl_dr_reg);
    assign rr_m2  = rr_u - (RW+1)'(2);
    assign cc_u   = {1'b0, blur_col_reg} + (CW+1)'(bl_dc_reg);
    assign cc_m2  = cc_u - (CW+1)'(2);
    assign tap_ok = (rr_u >= (RW+1)'(2)) && (rr_m2 < {1'b0, h_eff})
                 && (cc_u >= (CW+1)'(2)) && (cc_m2 < (CW+1)'(w_eff));
    assign bl_raddr = {rr_m2[2:0], cc_m2[CW-1:0]};

    // blurred-line read address: Sobel tap or the output position itself
    logic [1:0]       sb_row;
    logic [CW-1:0]    sb_col;
    logic [BL_AW-1:0] bl_raddr2;
    assign sb_row    = out_row_reg[1:0] + sb_i_reg - 2'd1;
    assign sb_col    = out_col_reg + CW'(sb_j_reg) - CW'(1);
    assign bl_raddr2 = cmd.sb_rd ? {sb_row, sb_col} : {out_row_reg[1:0], out_col_reg};

    logic signed [11:0] px;
    logic signed [23:0] sqy;
    logic [7:0]         rt_try;
    logic [15:0]        rt_sq;
    assign px     = $signed({4'b0, bl_rdata_reg});
    assign sqy    = gy_reg * gy_reg;
    assign rt_try = root_reg | (8'd1 << rt_bit_reg);
    assign rt_sq  = rt_try * rt_try;

    logic [7:0] edge_val;
    always_comb
    begin
        priority if (border)
        begin
            edge_val = 8'd0;
        end
        else if (sum_reg[21:16] != '0)
        begin
            edge_val = 8'd255;
        end
        else
        begin
            edge_val = root_reg;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.in_write)
        begin
            in_mem[{in_row_reg[2:0], in_col_reg}] <= pixel_reg;
        end
        if (cmd.bl_rd)
        begin
            in_rdata_reg <= in_mem[bl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bl_wr)
        begin
            bl_mem[{blur_row_reg[1:0], blur_col_reg}] <= prod_reg[DIV_SHIFT +: 8];
        end
        if (cmd.sb_rd || cmd.bv_rd)
        begin
            bl_rdata_reg <= bl_mem[bl_raddr2];
        end
    end

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            blur_row_reg <= '0;
            blur_col_reg <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            tick_reg     <= '0;
        end
        else if (cfg_write || (cmd.out_load && last))
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            blur_row_reg <= '0;
            blur_col_reg <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            tick_reg     <= '0;
        end
        else
        begin
            if (cmd.in_write)
            begin
                in_col_reg <= in_wrap ? '0 : in_col_reg + CW'(1);
                in_row_reg <= in_wrap ? in_row_reg + RW'(1) : in_row_reg;
            end
            if (cmd.bl_wr)
            begin
                blur_col_reg <= blur_wrap ? '0 : blur_col_reg + CW'(1);
                blur_row_reg <= blur_wrap ? blur_row_reg + RW'(1) : blur_row_reg;
            end
            if (cmd.tick_inc)
            begin
                tick_reg <= tick_reg + TW'(1);
            end
            if (cmd.out_load)
            begin
                out_col_reg <= out_wrap ? '0 : out_col_reg + CW'(1);
                out_row_reg <= out_wrap ? out_row_reg + RW'(1) : out_row_reg;
            end
        end
    end

    // arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= in_data.op;
            pixel_reg <= in_data.pixel;
        end
        if (cmd.bl_start)
        begin
            bl_dr_reg <= '0;
            bl_dc_reg <= '0;
            acc_reg   <= '0;
        end
        if (cmd.bl_rd)
        begin
            tap_ok_reg <= tap_ok;
            coef_reg   <= GAUSS_K[bl_dr_reg][bl_dc_reg];
        end
        if (cmd.bl_acc)
        begin
            acc_reg <= acc_reg + (tap_ok_reg ? 16'(in_rdata_reg) * 16'(coef_reg) : 16'd0);
            if (bl_dc_reg == 3'd4)
            begin
                bl_dc_reg <= '0;
                bl_dr_reg <= bl_dr_reg + 3'd1;
            end
            else
            begin
                bl_dc_reg <= bl_dc_reg + 3'd1;
            end
        end
        if (cmd.bl_div)
        begin
            prod_reg <= acc_reg * DIV_MUL;
        end
        if (cmd.bv_cap)
        begin
            bv_reg <= bl_rdata_reg;
        end
        if (cmd.sb_start)
        begin
            sb_i_reg <= '0;
            sb_j_reg <= '0;
            gx_reg   <= '0;
            gy_reg   <= '0;
        end
        if (cmd.sb_acc)
        begin
            gx_reg <= gx_reg + px * 12'(SOBEL_X[sb_i_reg][sb_j_reg]);
            gy_reg <= gy_reg + px * 12'(SOBEL_Y[sb_i_reg][sb_j_reg]);
            if (sb_j_reg == 2'd2)
            begin
                sb_j_reg <= '0;
                sb_i_reg <= sb_i_reg + 2'd1;
            end
            else
            begin
                sb_j_reg <= sb_j_reg + 2'd1;
            end
        end
        if (cmd.sq)
        begin
            sqx_reg <= gx_reg * gx_reg;
        end
        if (cmd.sum)
        begin
            sum_reg    <= 22'(sqx_reg + sqy);
            root_reg   <= '0;
            rt_bit_reg <= 3'd7;
        end
        if (cmd.rt_step)
        begin
            if (rt_sq <= sum_reg[15:0])
            begin
                root_reg <= rt_try;
            end
            rt_bit_reg <= rt_bit_reg - 3'd1;
        end
        if (cmd.out_load)
        begin
            out_data_reg.blurred    <= bv_reg;
            out_data_reg.edge_res   <= edge_val;
            out_data_reg.frame_last <= last;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.item_flush = (op_reg == OP_FLUSH);
    assign status.in_active  = (in_row_reg < h_eff);
    assign status.blur_go    = (tick_reg >= thr2) && (blur_row_reg < h_eff);
    assign status.out_go     = (tick_reg >= thr3);
    assign status.bl_last    = (bl_dr_reg == 3'd4) && (bl_dc_reg == 3'd4);
    assign status.sb_last    = (sb_i_reg == 2'd2) && (sb_j_reg == 2'd2);
    assign status.rt_last    = (rt_bit_reg == 3'd0);
    assign status.border     = border;
    assign status.out_full   = out_valid_reg;

endmodule

// File: sv/gaussian_blur_sobel_edge_top.sv
// gaussian_blur_sobel_edge_top: APB register file plus controller and
// datapath of the blur/edge block. Depends on gbse_pkg, gbse_ctrl, gbse_dp.
//
// Streams 8-bit grey pixels in raster order, blurs each with the 5x5
// Gaussian mask (zero padding, sum / 159) and takes the Sobel gradient
// magnitude of the blurred image, floor sqrt saturated to 255 and 0 on the
// frame border. A result pairs the blurred value and edge value of one
// position and appears 3 lines plus 3 pixels after that position's input;
// flush transfers (op = 1) push the tail of the frame out. A flush while the
// frame still expects pixels is dropped, and a pixel after the last one of
// the frame counts as a flush. frame_last marks the final result; the next
// pixel starts a new frame. Registers: frame_width at 0x0 and frame_height
// at 0x4; 0 acts as 1 and values above MAX_WIDTH / MAX_HEIGHT clamp. A
// register write restarts the frame and is only allowed while idle.
// One item at a time goes through a shared sequencer. A flush dropped
// mid-frame only passes the decide state; a tick with no blur and no
// result also passes the output check; a blur step adds 25 taps, a read and
// a MAC each, then scale and store; a result adds the blurred-value capture
// and the load on the frame border, and inside also one-port reads of 9
// blurred taps, two squares and 8 square-root steps. An item may also wait
// for the output register to empty. The finished result sits in an output
// register, so the next input transfer is taken while it waits.
module gaussian_blur_sobel_edge_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  gbse_pkg::gbse_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output gbse_pkg::gbse_out_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gbse_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_WIDTH)
            begin
                width_reg <= pwdata[10:0];
            end
            else
            begin
                height_reg <= pwdata[12:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT) ? {19'd0, height_reg} : {21'd0, width_reg};

    // effective frame size: 0 acts as 1, clamp to MAX_WIDTH / MAX_HEIGHT
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    always_comb
    begin
        priority if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
    end

    always_comb
    begin
        priority if (height_reg == '0)
        begin
            h_eff = RW'(1);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = RW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = RW'(height_reg);
        end
    end

    gbse_cmd_t    cmd;
    gbse_status_t status;

    gbse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gbse_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: sv/gbse_checker.sv
// gbse_checker: port-level assertions for the blur/edge block, bound to the
// top level. Depends on gbse_pkg and gaussian_blur_sobel_edge_top.
module gbse_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input gbse_pkg::gbse_out_t out_data,
    input logic                pready
);
    import gbse_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // an accepted item keeps the block busy the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // a new result only comes out of item processing
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a busy cycle");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind gaussian_blur_sobel_edge_top gbse_checker u_gbse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pready    (pready)
);

// File: tb/tb_gaussian_blur_sobel_edge_top.sv
// tb_gaussian_blur_sobel_edge_top: self-checking testbench for the blur/edge block.
// Depends on gbse_pkg and gaussian_blur_sobel_edge_top; no files or arguments.
// Predicts every result in a scoreboard class, drives with random idling.
module tb_gaussian_blur_sobel_edge_top;
    import gbse_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 4096;
    localparam int IDLE_LIMIT = 20000;  // cycles with no transfer before giving up
    localparam int SETTLE     = 150;    // margin for the slowest item to finish

    // Expected-result tracker: mirrors the line buffers, the position
    // counters and the frame registers, and queues the blurred/edge pairs
    // each accepted input transfer produces.
    class blur_edge_scoreboard;
        byte unsigned  in_lines [8][MAX_W];
        byte unsigned  bl_lines [4][MAX_W];
        int unsigned   width_reg;
        int unsigned   height_reg;
        int unsigned   in_row, in_col, bl_row, bl_col, out_row, out_col, ticks;
        gbse_out_t     pending[$];
        int            errors;
        int            results;
        int            frames;

        function new();
            width_reg  = 640;
            height_reg = 480;
            errors     = 0;
            results    = 0;
            frames     = 0;
            restart();
        endfunction

        function void restart();
            in_row  = 0; in_col  = 0;
            bl_row  = 0; bl_col  = 0;
            out_row = 0; out_col = 0;
            ticks   = 0;
        endfunction

        function int unsigned eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_H) return MAX_H;
            return height_reg;
        endfunction

        function void set_reg(logic idx, int unsigned val);
            if (idx == REG_WIDTH) width_reg = val & 32'h7FF;
            else                  height_reg = val & 32'h1FFF;
            restart();
        endfunction

        function bit in_tail();
            return in_row >= eff_h();
        endfunction

        // mask is symmetric: weight depends only on distance from center
        function int unsigned gauss_weight(int dr, int dc);
            int a;
            int b;
            a = (dr < 0) ? -dr : dr;
            b = (dc < 0) ? -dc : dc;
            if (a > b) begin
                int t;
                t = a; a = b; b = t;
            end
            case ({a[1:0], b[1:0]})
                4'b0000: return 15;
                4'b0001: return 12;
                4'b0010: return 5;
                4'b0101: return 9;
                4'b0110: return 4;
                default: return 2;
            endcase
        endfunction

        function byte unsigned blur_pixel(int r, int c, int w, int h);
            int unsigned acc;
            acc = 0;
            for (int dr = -2; dr <= 2; dr++)
                for (int dc = -2; dc <= 2; dc++)
                    if (r + dr >= 0 && r + dr < h && c + dc >= 0 && c + dc < w)
                        acc += in_lines[(r + dr) & 7][c + dc] * gauss_weight(dr, dc);
            return 8'(acc / 159);
        endfunction

        function byte unsigned root_sat(int unsigned s);
            int unsigned root;
            if (s >= 65536) return 255;
            root = 0;
            for (int b = 7; b >= 0; b--)
                if ((root + (1 << b)) * (root + (1 << b)) <= s) root += (1 << b);
            return 8'(root);
        endfunction

        function byte unsigned edge_mag(int r, int c, int w, int h);
            int p [3][3];
            int gx;
            int gy;
            if (w < 3 || h < 3 || r == 0 || c == 0 || r >= h - 1 || c >= w - 1) return 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    p[i][j] = bl_lines[(r + i - 1) & 3][c + j - 1];
            gx = (p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0]) + (p[2][2] - p[2][0]);
            gy = (p[2][0] - p[0][0]) + 2 * (p[2][1] - p[0][1]) + (p[2][2] - p[0][2]);
            return root_sat(gx * gx + gy * gy);
        endfunction

        function void step(ref int unsigned r, ref int unsigned c, input int unsigned w);
            c++;
            if (c >= w) begin
                c = 0;
                r++;
            end
        endfunction

        function void note_input(gbse_in_t item);
            int unsigned w;
            int unsigned h;
            gbse_out_t   res;
            w = eff_w();
            h = eff_h();
            if (in_row < h) begin
                if (item.op == OP_FLUSH) return;   // mid-frame flush is dropped
                in_lines[in_row & 7][in_col] = item.pixel;
                step(in_row, in_col, w);
            end
            if (ticks >= 2 * w + 2 && bl_row < h) begin
                bl_lines[bl_row & 3][bl_col] = blur_pixel(bl_row, bl_col, w, h);
                step(bl_row, bl_col, w);
            end
            if (ticks < 3 * w + 3) begin
                ticks++;
                return;
            end
            res.blurred    = bl_lines[out_row & 3][out_col];
            res.edge_res   = edge_mag(out_row, out_col, w, h);
            res.frame_last = (out_row == h - 1) && (out_col == w - 1);
            pending.push_back(res);
            if (res.frame_last) begin
                frames++;
                restart();
            end else begin
                step(out_row, out_col, w);
                ticks++;
            end
        endfunction

        function void check_result(gbse_out_t got);
            gbse_out_t want;
            results++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result blurred=%0d edge=%0d last=%0b",
                         $time, got.blurred, got.edge_res, got.frame_last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.blurred !== want.blurred) begin
                $display("%0t: blurred expected %0d actual %0d", $time, want.blurred, got.blurred);
                errors++;
            end
            if (got.edge_res !== want.edge_res) begin
                $display("%0t: edge_res expected %0d actual %0d",
                         $time, want.edge_res, got.edge_res);
                errors++;
            end
            if (got.frame_last !== want.frame_last) begin
                $display("%0t: frame_last expected %0b actual %0b",
                         $time, want.frame_last, got.frame_last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    gbse_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    gbse_out_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    blur_edge_scoreboard sb;
    int  sent_items;     // accepted input transfers
    int  idle_cycles;    // watchdog count
    int  cycle_no;
    bit  calm_in;        // stretch with no input gaps

    gaussian_blur_sobel_edge_top #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Output side: stall about a third of the time, except in a quiet
    // window of cycles where every result is taken at once.
    always @(negedge clk)
    begin
        if (cycle_no > 30000 && cycle_no < 60000)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 34);
    end

    // Result monitor, sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // Watchdog: any transfer on either channel resets the count.
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // One input transfer, with a random gap in front of it. The predictor
    // is updated at the edge where the transfer is taken.
    task automatic send_item(logic op, logic [7:0] pix);
        gbse_in_t item;
        item.op    = op;
        item.pixel = pix;
        if (!calm_in && $urandom_range(99) < 34)
        begin
            repeat ($urandom_range(1, 4))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(item);
        sent_items++;
    endtask

    task automatic park_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait until every expected result is out, then let a slow
    // result-less item finish before touching the registers.
    task automatic drain();
        park_input();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(logic idx, int unsigned val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        drain();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly well-formed frames: pixels until the frame is full, then
    // flushes until the last result. One item in ten is random noise.
    task automatic run_frames(int count);
        int goal;
        goal = sb.frames + count;
        while (sb.frames < goal)
        begin
            if ($urandom_range(9) == 0)
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            else if (sb.in_tail())
                send_item(OP_FLUSH, 8'($urandom_range(255)));
            else
                send_item(OP_PIXEL, pick_pixel());
        end
    endtask

    initial
    begin
        sb          = new();
        sent_items  = 0;
        idle_cycles = 0;
        cycle_no    = 0;
        calm_in     = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero registers act as a 1x1 frame
        set_frame(0, 0);
        send_item(OP_PIXEL, 8'd255);
        send_item(OP_FLUSH, 8'd0);
        send_item(OP_PIXEL, 8'd17);   // past the frame: counts as a flush
        run_frames(1);

        // 3x3: flush before any pixel is dropped; checkerboard of extremes
        set_frame(3, 3);
        send_item(OP_FLUSH, 8'd255);
        for (int i = 0; i < 9; i++)
            send_item(OP_PIXEL, (i % 2) ? 8'd0 : 8'd255);
        run_frames(1);

        // single column and single row: edge stays 0
        set_frame(1, 4);
        run_frames(1);
        set_frame(5, 1);
        run_frames(1);

        // oversized registers clamp; only a few items, no results
        set_frame(11'h7FF, 13'h1FFF);
        for (int i = 0; i < 6; i++)
            send_item(OP_PIXEL, (i % 2) ? 8'd255 : 8'd0);
        set_frame(MAX_W, MAX_H);
        for (int i = 0; i < 4; i++)
            send_item(OP_PIXEL, pick_pixel());

        // random frames of small sizes; a stretch with no input gaps
        set_frame(8, 6);
        while (sent_items < 1550)
        begin
            if ($urandom_range(3) == 0)
                set_frame($urandom_range(0, 16), $urandom_range(0, 8));
            calm_in = (sent_items > 600 && sent_items < 900);
            run_frames($urandom_range(1, 2));
        end
        calm_in = 1'b0;
        drain();

        $display("covered %0d input transfers, %0d results, %0d frames",
                 sent_items, sb.results, sb.frames);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: filelist.f
sv/gbse_pkg.sv
sv/gbse_ctrl.sv
sv/gbse_dp.sv
sv/gaussian_blur_sobel_edge_top.sv
sv/gbse_checker.sv
tb/tb_gaussian_blur_sobel_edge_top.sv
